/* rtl/ddtt_pkg.sv */
// ----------------------------------------------------------------------------
// ddtt_pkg
// Shared types and constants for the delimited decimal tape tokenizer.
// ----------------------------------------------------------------------------
package ddtt_pkg;

  localparam int CELL_BITS_DEF = 32;
  localparam int RUN_CHARS_DEF = 32;

  // Configuration port
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 64;
  localparam int REG_SEL_BIT = 3;
  localparam logic REG_MASK_LOW  = 1'b0;
  localparam logic REG_MASK_HIGH = 1'b1;

  // Input item kinds
  localparam logic FUNC_TEXT = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam logic [7:0] MINUS_CHAR = 8'd45;
  localparam logic [7:0] DIGIT_LO   = 8'd48;
  localparam logic [7:0] DIGIT_HI   = 8'd57;

  // Source of an output cell
  typedef enum logic [2:0] {
    SEL_BYTE,
    SEL_FIRST,
    SEL_DEC,
    SEL_MEM,
    SEL_HOLD
  } emit_sel_t;

  typedef struct packed {
    logic      emit;
    emit_sel_t sel;
    logic      use_ovf;
    logic      last;
    logic      start_run;
    logic      append;
    logic      clear_run;
    logic      hold_break;
    logic      rd_start;
    logic      rd_next;
  } dp_cmd_t;

  typedef struct packed {
    logic digit;
    logic minus;
    logic delim;
    logic passthru;
    logic out_free;
    logic last_char;
  } dp_stat_t;

endpackage

/* rtl/ddtt_regs.sv */
// ----------------------------------------------------------------------------
// ddtt_regs
// APB-style register file holding the two delimiter masks.
// ----------------------------------------------------------------------------
module ddtt_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ddtt_pkg::ADDR_W-1:0]   paddr,
  input  logic [ddtt_pkg::DATA_W-1:0]   pwdata,
  output logic [ddtt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [63:0]                   delim_mask_low,
  output logic [63:0]                   delim_mask_high
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_mask_low  <= '0;
      delim_mask_high <= '0;
    end else if (wr_en) begin
      unique case (paddr[ddtt_pkg::REG_SEL_BIT])
        ddtt_pkg::REG_MASK_LOW:  delim_mask_low  <= pwdata;
        ddtt_pkg::REG_MASK_HIGH: delim_mask_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ddtt_pkg::REG_SEL_BIT])
      ddtt_pkg::REG_MASK_LOW:  prdata = delim_mask_low;
      ddtt_pkg::REG_MASK_HIGH: prdata = delim_mask_high;
      default:                 prdata = '0;
    endcase
  end

endmodule

/* rtl/ddtt_ctrl.sv */
// ----------------------------------------------------------------------------
// ddtt_ctrl
// Parser state machine and run replay sequencer.
// ----------------------------------------------------------------------------
module ddtt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  input  logic               func,
  input  ddtt_pkg::dp_stat_t stat,
  output logic               text_stall,
  output ddtt_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    MODE_START,
    MODE_DELIM,
    MODE_TEXT,
    MODE_RUN1,
    MODE_RUN2
  } mode_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_FETCH,
    SEQ_EMIT,
    SEQ_TAIL
  } seq_t;

  mode_t mode, mode_next;
  seq_t  seq, seq_next;
  logic  accept;
  logic  brk;

  assign text_stall = (seq != SEQ_IDLE) || !stat.out_free;
  assign accept     = text_valid && !text_stall;

  always_comb begin
    cmd       = '0;
    cmd.sel   = ddtt_pkg::SEL_BYTE;
    mode_next = mode;
    seq_next  = seq;
    brk       = 1'b0;

    unique case (seq)
      SEQ_IDLE: begin
        if (accept) begin
          if (func == ddtt_pkg::FUNC_END) begin
            // flush pending run
            if (mode == MODE_RUN1) begin
              cmd.emit    = 1'b1;
              cmd.sel     = ddtt_pkg::SEL_FIRST;
              cmd.use_ovf = 1'b1;
              cmd.last    = 1'b1;
            end else if (mode == MODE_RUN2) begin
              cmd.emit    = 1'b1;
              cmd.sel     = ddtt_pkg::SEL_DEC;
              cmd.use_ovf = 1'b1;
              cmd.last    = 1'b1;
            end
            cmd.clear_run = 1'b1;
            mode_next     = MODE_START;
          end else if (stat.passthru) begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
          end else begin
            unique case (mode)
              MODE_TEXT: begin
                if (stat.delim) begin
                  mode_next = MODE_DELIM;
                end else begin
                  cmd.emit = 1'b1;
                  cmd.last = 1'b1;
                end
              end
              MODE_RUN1: begin
                priority if (stat.delim) begin
                  cmd.emit      = 1'b1;
                  cmd.sel       = ddtt_pkg::SEL_FIRST;
                  cmd.use_ovf   = 1'b1;
                  cmd.last      = 1'b1;
                  cmd.clear_run = 1'b1;
                  mode_next     = MODE_DELIM;
                end else if (stat.digit) begin
                  cmd.append = 1'b1;
                  mode_next  = MODE_RUN2;
                end else begin
                  brk = 1'b1;
                end
              end
              MODE_RUN2: begin
                priority if (stat.digit) begin
                  cmd.append = 1'b1;
                end else if (stat.delim) begin
                  cmd.emit      = 1'b1;
                  cmd.sel       = ddtt_pkg::SEL_DEC;
                  cmd.use_ovf   = 1'b1;
                  cmd.last      = 1'b1;
                  cmd.clear_run = 1'b1;
                  mode_next     = MODE_DELIM;
                end else begin
                  brk = 1'b1;
                end
              end
              default: begin
                // start of text or after a delimiter
                priority if (stat.digit || stat.minus) begin
                  cmd.start_run = 1'b1;
                  mode_next     = MODE_RUN1;
                end else if (stat.delim) begin
                  mode_next = MODE_DELIM;
                end else begin
                  cmd.emit  = 1'b1;
                  cmd.last  = 1'b1;
                  mode_next = MODE_TEXT;
                end
              end
            endcase
            if (brk) begin
              // broken run: replay buffered chars, then the breaking byte
              cmd.hold_break = 1'b1;
              cmd.rd_start   = 1'b1;
              mode_next      = MODE_TEXT;
              seq_next       = SEQ_FETCH;
            end
          end
        end
      end
      SEQ_FETCH: begin
        seq_next = SEQ_EMIT;
      end
      SEQ_EMIT: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = ddtt_pkg::SEL_MEM;
          cmd.use_ovf = 1'b1;
          cmd.rd_next = 1'b1;
          seq_next    = stat.last_char ? SEQ_TAIL : SEQ_FETCH;
        end
      end
      SEQ_TAIL: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = ddtt_pkg::SEL_HOLD;
          cmd.use_ovf   = 1'b1;
          cmd.last      = 1'b1;
          cmd.clear_run = 1'b1;
          seq_next      = SEQ_IDLE;
        end
      end
      default: seq_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_START;
      seq  <= SEQ_IDLE;
    end else begin
      mode <= mode_next;
      seq  <= seq_next;
    end
  end

endmodule

/* rtl/ddtt_dpath.sv */
// ----------------------------------------------------------------------------
// ddtt_dpath
// Run buffer, decimal accumulator, delimiter decode and output register.
// ----------------------------------------------------------------------------
module ddtt_dpath #(
  parameter int CELL_BITS = ddtt_pkg::CELL_BITS_DEF,
  parameter int RUN_CHARS = ddtt_pkg::RUN_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         text_byte,
  input  logic [63:0]        delim_mask_low,
  input  logic [63:0]        delim_mask_high,
  input  ddtt_pkg::dp_cmd_t  cmd,
  output ddtt_pkg::dp_stat_t stat,
  input  logic               cell_stall,
  output logic               cell_valid,
  output logic signed [31:0] cell_res,
  output logic               run_truncated,
  output logic               last_of_item
);

  localparam int LEN_W = $clog2(RUN_CHARS + 1);
  localparam int IDX_W = $clog2(RUN_CHARS);

  logic [7:0]           run_mem [RUN_CHARS];
  logic [7:0]           rd_data;
  logic [IDX_W-1:0]     rd_idx;
  logic [LEN_W-1:0]     run_length;
  logic [CELL_BITS-1:0] run_value;
  logic                 run_negative;
  logic                 run_overflow;
  logic [7:0]           run_first;
  logic [7:0]           break_byte;

  logic                 room;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [CELL_BITS-1:0] digit_val;
  logic [CELL_BITS-1:0] dec_val;
  logic [CELL_BITS-1:0] cval;
  logic [127:0]         mask_all;

  assign mask_all       = {delim_mask_high, delim_mask_low};
  assign stat.digit     = (text_byte >= ddtt_pkg::DIGIT_LO) && (text_byte <= ddtt_pkg::DIGIT_HI);
  assign stat.minus     = (text_byte == ddtt_pkg::MINUS_CHAR);
  assign stat.delim     = !text_byte[7] && mask_all[text_byte[6:0]];
  assign stat.passthru  = (delim_mask_low == '0) && (delim_mask_high == '0);
  assign stat.out_free  = !cell_valid || !cell_stall;
  assign stat.last_char = (LEN_W'(rd_idx) == run_length - LEN_W'(1));

  assign room      = (run_length < LEN_W'(RUN_CHARS));
  assign wr_en     = cmd.start_run || (cmd.append && room);
  assign wr_addr   = cmd.start_run ? '0 : run_length[IDX_W-1:0];
  assign digit_val = CELL_BITS'(text_byte[3:0]);
  assign dec_val   = run_negative ? (-run_value) : run_value;

  // run buffer: one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      run_mem[wr_addr] <= text_byte;
    end
    rd_data <= run_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length   <= '0;
      run_value    <= '0;
      run_negative <= 1'b0;
      run_overflow <= 1'b0;
      rd_idx       <= '0;
    end else begin
      if (cmd.clear_run) begin
        run_length   <= '0;
        run_value    <= '0;
        run_negative <= 1'b0;
        run_overflow <= 1'b0;
      end else if (cmd.start_run) begin
        run_length   <= LEN_W'(1);
        run_negative <= stat.minus;
        run_overflow <= 1'b0;
        run_value    <= stat.minus ? '0 : digit_val;
      end else if (cmd.append) begin
        if (room) begin
          run_length <= run_length + LEN_W'(1);
          run_value  <= (run_value << 3) + (run_value << 1) + digit_val;
        end else begin
          run_overflow <= 1'b1;
        end
      end
      if (cmd.rd_start) begin
        rd_idx <= '0;
      end else if (cmd.rd_next) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_run) begin
      run_first <= text_byte;
    end
    if (cmd.hold_break) begin
      break_byte <= text_byte;
    end
  end

  always_comb begin
    unique case (cmd.sel)
      ddtt_pkg::SEL_BYTE:  cval = CELL_BITS'(text_byte);
      ddtt_pkg::SEL_FIRST: cval = CELL_BITS'(run_first);
      ddtt_pkg::SEL_DEC:   cval = dec_val;
      ddtt_pkg::SEL_MEM:   cval = CELL_BITS'(rd_data);
      ddtt_pkg::SEL_HOLD:  cval = CELL_BITS'(break_byte);
      default:             cval = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (cmd.emit) begin
      cell_valid <= 1'b1;
    end else if (!cell_stall) begin
      cell_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cell_res      <= 32'($signed(cval));
      run_truncated <= cmd.use_ovf && run_overflow;
      last_of_item  <= cmd.last;
    end
  end

endmodule

/* rtl/delimited_decimal_tape_tokenizer.sv */
// ----------------------------------------------------------------------------
// delimited_decimal_tape_tokenizer
// Top level: text bytes in, tape cells out, delimiter masks over APB.
// ----------------------------------------------------------------------------
// Takes one text byte (or an end-of-text item) per cycle while text_stall
// is low, and produces tape cells on a registered output. With both
// delimiter masks zero every byte is passed through as one cell. Otherwise
// delimiter bytes are dropped and runs of an optional minus plus digits,
// starting at the start of text or after a delimiter, are buffered and
// turned into one signed decimal cell wrapped to CELL_BITS; a one-char run
// comes out as that char. An item that breaks a buffered run replays its
// chars from the run buffer, a memory with one write port and registered
// read, each char fetched, then emitted, and then emits the breaking byte;
// text_stall stays high until that byte has been emitted. Any cycle where
// the output register holds an untaken cell also stalls input. The run
// buffer needs no clearing pass after reset; chars past RUN_CHARS are
// dropped and the resulting cells carry run_truncated. Delimiter masks are
// written over APB at byte addresses 0 (bytes 0..63) and 8 (bytes
// 64..127); the user must write them only while the block is idle, as the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module delimited_decimal_tape_tokenizer #(
  parameter int CELL_BITS = ddtt_pkg::CELL_BITS_DEF,
  parameter int RUN_CHARS = ddtt_pkg::RUN_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input item channel
  input  logic                        text_valid,
  output logic                        text_stall,
  input  logic                        func,
  input  logic [7:0]                  text_byte,
  // result item channel
  output logic                        cell_valid,
  input  logic                        cell_stall,
  output logic signed [31:0]          cell_res,
  output logic                        run_truncated,
  output logic                        last_of_item,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ddtt_pkg::ADDR_W-1:0] paddr,
  input  logic [ddtt_pkg::DATA_W-1:0] pwdata,
  output logic [ddtt_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  logic [63:0]        delim_mask_low;
  logic [63:0]        delim_mask_high;
  ddtt_pkg::dp_cmd_t  cmd;
  ddtt_pkg::dp_stat_t stat;

  ddtt_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .delim_mask_low  (delim_mask_low),
    .delim_mask_high (delim_mask_high)
  );

  // parser FSM plus replay sequencer
  ddtt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .func       (func),
    .stat       (stat),
    .text_stall (text_stall),
    .cmd        (cmd)
  );

  // run buffer, accumulator, output register
  ddtt_dpath #(
    .CELL_BITS (CELL_BITS),
    .RUN_CHARS (RUN_CHARS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .text_byte       (text_byte),
    .delim_mask_low  (delim_mask_low),
    .delim_mask_high (delim_mask_high),
    .cmd             (cmd),
    .stat            (stat),
    .cell_stall      (cell_stall),
    .cell_valid      (cell_valid),
    .cell_res        (cell_res),
    .run_truncated   (run_truncated),
    .last_of_item    (last_of_item)
  );

endmodule

/* rtl/ddtt_checker.sv */
// ----------------------------------------------------------------------------
// ddtt_checker
// Port-level checks for the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module ddtt_checker (
  input logic               clk,
  input logic               rst,
  input logic               text_stall,
  input logic               cell_valid,
  input logic               cell_stall,
  input logic signed [31:0] cell_res,
  input logic               last_of_item
);

  // a held cell blocks new input
  a_held_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cell_valid && cell_stall) |-> text_stall)
    else $error("input accepted while a result is held");

  // more results of the same item pending: no new item may enter
  a_replay_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cell_valid && !last_of_item) |-> text_stall)
    else $error("input accepted in the middle of an item's results");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (cell_valid && cell_stall) |=> (cell_valid && $stable(cell_res)))
    else $error("stalled result changed");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !cell_valid)
    else $error("result valid after reset");

endmodule

bind delimited_decimal_tape_tokenizer ddtt_checker u_ddtt_checker (
  .clk          (clk),
  .rst          (rst),
  .text_stall   (text_stall),
  .cell_valid   (cell_valid),
  .cell_stall   (cell_stall),
  .cell_res     (cell_res),
  .last_of_item (last_of_item)
);

/* tb/ddtt_checker.sv */
// ----------------------------------------------------------------------------
// ddtt_scoreboard
// Predicts and checks the tape cells of the delimited decimal tape tokenizer.
// ----------------------------------------------------------------------------
// Snoops the text channel, the cell channel and APB writes. Every accepted
// text item runs through a local tokenizer model, and the cells it yields are
// queued. Every accepted cell is compared field by field with the oldest
// queued one. Mismatch count and queue depth go back to the testbench top.
// ----------------------------------------------------------------------------
module ddtt_scoreboard #(
  parameter int CELL_BITS = ddtt_pkg::CELL_BITS_DEF,
  parameter int RUN_CHARS = ddtt_pkg::RUN_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        text_valid,
  input  logic                        text_stall,
  input  logic                        func,
  input  logic [7:0]                  text_byte,
  input  logic                        cell_valid,
  input  logic                        cell_stall,
  input  logic signed [31:0]          cell_res,
  input  logic                        run_truncated,
  input  logic                        last_of_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ddtt_pkg::ADDR_W-1:0] paddr,
  input  logic [ddtt_pkg::DATA_W-1:0] pwdata,
  output int                          errors,
  output int                          pending
);

  typedef enum logic [2:0] {
    MODE_START,
    MODE_DELIM,
    MODE_TEXT,
    MODE_RUN1,
    MODE_RUN2
  } parse_mode_t;

  typedef struct packed {
    logic [31:0] val;
    logic        trunc;
    logic        last;
  } tape_cell_t;

  localparam logic [63:0] CELL_MASK =
    (CELL_BITS >= 64) ? '1 : ((64'd1 << CELL_BITS) - 64'd1);

  logic [63:0] delim_lo = '0;
  logic [63:0] delim_hi = '0;
  parse_mode_t mode = MODE_START;
  logic [7:0]  run_buf [RUN_CHARS];
  int          run_len = 0;
  logic [63:0] run_mag = '0;
  logic        run_neg = 1'b0;
  logic        run_ovf = 1'b0;
  tape_cell_t  due_cells [$];
  tape_cell_t  item_cells [$];
  int          fail_count = 0;

  task automatic report(input string msg);
    fail_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // wrap to CELL_BITS, sign-extend, cut to the 32-bit port
  function automatic logic [31:0] to_cell(input logic [63:0] v);
    logic [63:0] w;
    w = v & CELL_MASK;
    if (w[CELL_BITS-1]) begin
      w = w | ~CELL_MASK;
    end
    return w[31:0];
  endfunction

  // bytes 128 and up are never delimiters
  function automatic logic is_delim(input logic [7:0] b);
    if (b < 8'd64) return delim_lo[b[5:0]];
    if (b < 8'd128) return delim_hi[b[5:0]];
    return 1'b0;
  endfunction

  task automatic put_cell(input logic [63:0] v, input logic trunc);
    tape_cell_t c;
    c.val   = to_cell(v);
    c.trunc = trunc;
    c.last  = 1'b0;
    item_cells.push_back(c);
  endtask

  task automatic drop_run();
    run_len = 0;
    run_mag = '0;
    run_neg = 1'b0;
    run_ovf = 1'b0;
  endtask

  task automatic open_run(input logic [7:0] b);
    drop_run();
    run_buf[0] = b;
    run_len    = 1;
    if (b == ddtt_pkg::MINUS_CHAR) begin
      run_neg = 1'b1;
    end else begin
      run_mag = 64'(b - ddtt_pkg::DIGIT_LO);
    end
  endtask

  // digits past the buffer are lost from both value and replay
  task automatic add_digit(input logic [7:0] b);
    if (run_len < RUN_CHARS) begin
      run_buf[run_len] = b;
      run_len++;
      run_mag = (run_mag * 64'd10 + 64'(b - ddtt_pkg::DIGIT_LO)) & CELL_MASK;
    end else begin
      run_ovf = 1'b1;
    end
  endtask

  task automatic put_decimal();
    logic [63:0] v;
    v = run_mag & CELL_MASK;
    if (run_neg) begin
      v = (64'd0 - v) & CELL_MASK;
    end
    put_cell(v, run_ovf);
  endtask

  task automatic put_replay();
    for (int i = 0; i < run_len; i++) begin
      put_cell(64'(run_buf[i]), run_ovf);
    end
  endtask

  // one text item -> zero or more tape cells, appended to due_cells
  task automatic tokenize(input logic f, input logic [7:0] b);
    logic       digit;
    logic       minus;
    logic       dl;
    tape_cell_t c;
    digit = (b >= ddtt_pkg::DIGIT_LO) && (b <= ddtt_pkg::DIGIT_HI);
    minus = (b == ddtt_pkg::MINUS_CHAR);
    item_cells.delete();
    if (f == ddtt_pkg::FUNC_END) begin
      if (mode == MODE_RUN1) begin
        put_cell(64'(run_buf[0]), run_ovf);
      end else if (mode == MODE_RUN2) begin
        put_decimal();
      end
      mode = MODE_START;
      drop_run();
    end else if (delim_lo == '0 && delim_hi == '0) begin
      // passthrough; a pending run stays parked
      put_cell(64'(b), 1'b0);
    end else begin
      dl = is_delim(b);
      case (mode)
        MODE_TEXT: begin
          if (dl) mode = MODE_DELIM;
          else put_cell(64'(b), 1'b0);
        end
        MODE_RUN1: begin
          if (dl) begin
            put_cell(64'(run_buf[0]), run_ovf);
            drop_run();
            mode = MODE_DELIM;
          end else if (digit) begin
            add_digit(b);
            mode = MODE_RUN2;
          end else begin
            put_replay();
            put_cell(64'(b), run_ovf);
            drop_run();
            mode = MODE_TEXT;
          end
        end
        MODE_RUN2: begin
          if (digit) begin
            add_digit(b);
          end else if (dl) begin
            put_decimal();
            drop_run();
            mode = MODE_DELIM;
          end else begin
            put_replay();
            put_cell(64'(b), run_ovf);
            drop_run();
            mode = MODE_TEXT;
          end
        end
        default: begin
          // char test ahead of delimiter test here
          if (digit || minus) begin
            open_run(b);
            mode = MODE_RUN1;
          end else if (dl) begin
            mode = MODE_DELIM;
          end else begin
            put_cell(64'(b), 1'b0);
            mode = MODE_TEXT;
          end
        end
      endcase
    end
    if (item_cells.size() > 0) begin
      c      = item_cells.pop_back();
      c.last = 1'b1;
      item_cells.push_back(c);
    end
    foreach (item_cells[i]) due_cells.push_back(item_cells[i]);
  endtask

  task automatic check_cell();
    tape_cell_t w;
    if (due_cells.size() == 0) begin
      report($sformatf("cell %0d arrived with nothing outstanding", cell_res));
      return;
    end
    w = due_cells.pop_front();
    if (cell_res !== w.val) begin
      report($sformatf("cell_res %0d, want %0d", cell_res, $signed(w.val)));
    end
    if (run_truncated !== w.trunc) begin
      report($sformatf("run_truncated %b, want %b", run_truncated, w.trunc));
    end
    if (last_of_item !== w.last) begin
      report($sformatf("last_of_item %b, want %b", last_of_item, w.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      delim_lo = '0;
      delim_hi = '0;
      mode     = MODE_START;
      drop_run();
      due_cells.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[ddtt_pkg::REG_SEL_BIT] == ddtt_pkg::REG_MASK_HIGH) delim_hi = pwdata;
        else delim_lo = pwdata;
      end
      if (text_valid && !text_stall) tokenize(func, text_byte);
      if (cell_valid && !cell_stall) check_cell();
    end
    pending <= due_cells.size();
    errors  <= fail_count;
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Regression bench for the delimited decimal tape tokenizer.
// ----------------------------------------------------------------------------
// Drives text items and APB mask writes, stalls the cell side at random and
// leaves all prediction and comparison to ddtt_scoreboard. A short directed
// pass covers passthrough, decimal runs, lone chars, broken runs and masks
// cleared in the middle of a run; random phases then sweep several mask
// settings with well-formed number runs as the largest share, plus noise.
// ----------------------------------------------------------------------------
module tb;

  localparam int ITEMS       = 300;  // stop offering random text past this
  localparam int MAX_GAP     = 19;
  localparam int HOLD_AT     = 160;  // item count that kicks off the long stall
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 8;    // settle time once nothing is outstanding
  localparam int IDLE_LIMIT  = 3000; // watchdog: cycles with no handshake at all

  // tab, LF, CR, space, comma
  localparam logic [63:0] WS_MASK = (64'd1 << 9) | (64'd1 << 10) | (64'd1 << 13) |
                                    (64'd1 << 32) | (64'd1 << 44);
  // digits and minus as delimiters too
  localparam logic [63:0] NUM_MASK = (64'h3FF << 48) | (64'd1 << 45);
  localparam logic [63:0] EDGE_BITS = 64'h8000_0000_0000_0001;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        text_valid = 1'b0;
  logic                        text_stall;
  logic                        func       = ddtt_pkg::FUNC_TEXT;
  logic [7:0]                  text_byte  = 8'h00;
  logic                        cell_valid;
  logic                        cell_stall = 1'b0;
  logic signed [31:0]          cell_res;
  logic                        run_truncated;
  logic                        last_of_item;
  logic                        psel       = 1'b0;
  logic                        penable    = 1'b0;
  logic                        pwrite     = 1'b0;
  logic [ddtt_pkg::ADDR_W-1:0] paddr      = '0;
  logic [ddtt_pkg::DATA_W-1:0] pwdata     = '0;
  logic [ddtt_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  int errors;
  int pending;

  int           items_sent  = 0;
  int           phase_items = 0;
  bit           tx_calm     = 1'b0;  // phase with no sender gaps
  bit           rx_calm     = 1'b0;  // phase with no receiver stalls
  logic [127:0] delim_set   = '0;    // mirror of the masks, for stimulus only
  int           rx_wait     = 0;
  int           hold_left   = 0;
  bit           hold_done   = 1'b0;
  int           idle_cycles = 0;

  always #10 clk = ~clk;

  delimited_decimal_tape_tokenizer dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .func         (func),
    .text_byte    (text_byte),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .cell_res     (cell_res),
    .run_truncated(run_truncated),
    .last_of_item (last_of_item),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  ddtt_scoreboard cell_check (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .func         (func),
    .text_byte    (text_byte),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .cell_res     (cell_res),
    .run_truncated(run_truncated),
    .last_of_item (last_of_item),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .errors       (errors),
    .pending      (pending)
  );

  // Wait drawn per item; zero at least a third of the time so bursts happen too.
  function automatic int draw_wait();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [7:0] pick_delim();
    logic [7:0] b;
    for (int k = 0; k < 200; k++) begin
      b = 8'($urandom_range(0, 127));
      if (delim_set[b[6:0]]) return b;
    end
    // no delimiters set (passthrough): any byte will do
    return 8'($urandom_range(0, 255));
  endfunction

  // A byte that is neither digit, minus nor delimiter: breaks a run.
  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    for (int k = 0; k < 100; k++) begin
      b = 8'($urandom_range(0, 255));
      if (!(b >= ddtt_pkg::DIGIT_LO && b <= ddtt_pkg::DIGIT_HI) &&
          b != ddtt_pkg::MINUS_CHAR &&
          !(b < 8'd128 && delim_set[b[6:0]])) return b;
    end
    return 8'($urandom_range(128, 255));
  endfunction

  // APB write: setup then access. psel stays up so back-to-back writes
  // never drop and raise it in the same step; the caller closes the burst.
  task automatic write_reg(input logic idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ddtt_pkg::ADDR_W'(idx) << ddtt_pkg::REG_SEL_BIT;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_masks(input logic [63:0] lo, input logic [63:0] hi);
    write_reg(ddtt_pkg::REG_MASK_LOW, lo);
    write_reg(ddtt_pkg::REG_MASK_HIGH, hi);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    delim_set = {hi, lo};
  endtask

  // Offer one item and hold it until taken. valid is only lowered when a
  // gap is drawn, so a back-to-back item never toggles it within a step.
  task automatic send_item(input logic f, input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : draw_wait();
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    func       <= f;
    text_byte  <= b;
    do @(posedge clk); while (text_stall);
    items_sent++;
    phase_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(ddtt_pkg::FUNC_TEXT, s[i]);
    end
  endtask

  // Stop offering, wait for every outstanding cell, then a short drain so a
  // delimiter still in flight cannot race the next mask write.
  task automatic settle();
    text_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic phase_config(input int k);
    case (k % 7)
      0: set_masks(WS_MASK, '0);
      1: set_masks('1, '1);                           // every ASCII byte delimits
      2: set_masks('0, {$urandom, $urandom} | (64'd1 << 60));  // high mask only
      3: set_masks(WS_MASK | NUM_MASK, '0);
      4: set_masks({$urandom, $urandom}, {$urandom, $urandom});
      5: set_masks('0, '0);                           // passthrough
      default: set_masks(WS_MASK | EDGE_BITS, EDGE_BITS); // bytes 0, 63, 64, 127
    endcase
  endtask

  // One random token. Number runs are the largest share (short, medium, and a
  // few near or past the run buffer size) with a delimiter, breaker or end behind
  // them; the rest is delimiter runs, plain words, raw noise and stray end items.
  task automatic random_token();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      n = $urandom_range(0, 99);
      n = (n < 85) ? $urandom_range(1, 5) :
          (n < 95) ? $urandom_range(6, 12) : $urandom_range(30, 40);
      if ($urandom_range(0, 2) == 0) begin
        send_item(ddtt_pkg::FUNC_TEXT, ddtt_pkg::MINUS_CHAR);
        if ($urandom_range(0, 4) == 0) n = 0;  // lone minus
      end
      repeat (n) begin
        send_item(ddtt_pkg::FUNC_TEXT, ddtt_pkg::DIGIT_LO + 8'($urandom_range(0, 9)));
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_item(ddtt_pkg::FUNC_TEXT, pick_delim());
        6, 7: send_item(ddtt_pkg::FUNC_TEXT, pick_plain());
        8: send_item(ddtt_pkg::FUNC_END, 8'($urandom_range(0, 255)));
        default: ;
      endcase
    end else if (kind < 65) begin
      repeat ($urandom_range(1, 3)) send_item(ddtt_pkg::FUNC_TEXT, pick_delim());
    end else if (kind < 80) begin
      // plain word; digits inside it must stay plain chars
      send_item(ddtt_pkg::FUNC_TEXT, pick_plain());
      repeat ($urandom_range(0, 3)) begin
        send_item(ddtt_pkg::FUNC_TEXT,
                  $urandom_range(0, 1) ? ddtt_pkg::DIGIT_LO + 8'($urandom_range(0, 9))
                                       : 8'($urandom_range(0, 255)));
      end
    end else if (kind < 92) begin
      send_item(ddtt_pkg::FUNC_TEXT, 8'($urandom_range(0, 255)));
    end else begin
      send_item(ddtt_pkg::FUNC_END, 8'($urandom_range(0, 255)));
    end
  endtask

  // Cell side: a drawn stall after every taken cell, plus one long hold-off
  // partway through so the block backs up into text_stall.
  always @(posedge clk) begin
    if (rst) begin
      cell_stall <= 1'b0;
      rx_wait    = 0;
    end else begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (cell_valid && !cell_stall) begin
        rx_wait = rx_calm ? 0 : draw_wait();
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (hold_left > 0) hold_left--;
      cell_stall <= (rx_wait > 0) || (hold_left > 0);
    end
  end

  // Watchdog on handshake inactivity.
  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (cell_valid && !cell_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("delimited_decimal_tape_tokenizer regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int ph;
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // passthrough: byte extremes, a digit, an end item with nothing pending
    set_masks('0, '0);
    send_item(ddtt_pkg::FUNC_TEXT, 8'h00);
    send_item(ddtt_pkg::FUNC_TEXT, 8'hFF);
    send_item(ddtt_pkg::FUNC_TEXT, "7");
    send_item(ddtt_pkg::FUNC_END, 8'hFF);
    settle();

    // negative decimal, lone digit, broken run, digit after a plain char,
    // lone minus, decimal flushed by the end item, then a high byte
    set_masks(WS_MASK, '0);
    send_text("-12 7 -9a x3 - 42");
    send_item(ddtt_pkg::FUNC_END, 8'h00);
    send_item(ddtt_pkg::FUNC_TEXT, 8'h80);
    // leave a run parked, clear the masks, pass bytes, re-arm and finish it
    send_text(" -5");
    settle();
    set_masks('0, '0);
    send_item(ddtt_pkg::FUNC_TEXT, "9");
    settle();
    set_masks(WS_MASK, '0);
    send_text("2 ");
    settle();

    for (ph = 0; items_sent < ITEMS; ph++) begin
      phase_config(ph);
      tx_calm     = ($urandom_range(0, 3) == 0);
      rx_calm     = ($urandom_range(0, 3) == 0);
      phase_items = 0;
      n           = $urandom_range(25, 45);
      while (phase_items < n) random_token();
      if ($urandom_range(0, 1)) begin
        send_item(ddtt_pkg::FUNC_END, 8'($urandom_range(0, 255)));
      end
      settle();
    end

    if (errors == 0) begin
      $display("delimited_decimal_tape_tokenizer regression: pass");
    end else begin
      $display("delimited_decimal_tape_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
